// File: src/stbs_pkg.sv
`timescale 1ns / 1ps
// Package for the sorted table binary search block.
// Holds operation codes, field widths and the control and status structs.
// It has no dependencies.
package stbs_pkg;

  localparam int OP_W  = 2;
  localparam int VAL_W = 32;
  localparam int POS_W = 11;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef struct packed {
    logic load;
    logic clear;
    logic start;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic done;
  } status_t;

endpackage

// File: src/stbs_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input items and the result items.
// Depends on stbs_pkg for the field widths.
interface stbs_in_if;
  logic                            valid;
  logic                            ready;
  logic [stbs_pkg::OP_W-1:0]       op;
  logic signed [stbs_pkg::VAL_W-1:0] search_value;

  modport source (output valid, op, search_value, input ready);
  modport sink (input valid, op, search_value, output ready);
endinterface

interface stbs_out_if;
  logic                      valid;
  logic                      ready;
  logic [stbs_pkg::POS_W-1:0] position;
  logic                      found;

  modport source (output valid, position, found, input ready);
  modport sink (input valid, position, found, output ready);
endinterface

// File: src/sorted_table_binary_search_core.sv
`timescale 1ns / 1ps
// A load or a clear transfer is accepted and the block is ready again at
// once. A query issues the first probe when it is accepted, then probes the table
// memory's single synchronous read port once per search step, at most
// ceil(log2(count + 1)) probes (11 for a full table of 1024 entries), and the
// result is offered in the cycle after the last probe, where it waits until
// taken; no new transfer is accepted while a query is in flight. After reset
// the table is empty and no clearing pass is run. Values are expected in
// ascending order; position is the match index, or the insertion position.
// Depends on stbs_pkg, stbs_if, stbs_ctrl and stbs_datapath.
module sorted_table_binary_search_core #(
  parameter int TABLE_DEPTH = 1024
) (
  input logic        clk_i,
  input logic        rst_ni,
  stbs_in_if.sink    in_i,
  stbs_out_if.source out_o
);

  stbs_pkg::cmd_t    cmd;
  stbs_pkg::status_t status;

  stbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_op_i     (in_i.op),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  stbs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .value_i    (in_i.search_value),
    .status_o   (status),
    .position_o (out_o.position),
    .found_o    (out_o.found)
  );

endmodule

// File: src/stbs_datapath.sv
`timescale 1ns / 1ps
// Datapath of the binary search block: table memory, fill count, search bounds
// and the result register. Driven by stbs_ctrl through stbs_pkg::cmd_t.
module stbs_datapath #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  stbs_pkg::cmd_t                    cmd_i,
  input  logic signed [stbs_pkg::VAL_W-1:0] value_i,
  output stbs_pkg::status_t                 status_o,
  output logic [stbs_pkg::POS_W-1:0]        position_o,
  output logic                              found_o
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  logic signed [stbs_pkg::VAL_W-1:0] mem [TABLE_DEPTH];
  logic signed [stbs_pkg::VAL_W-1:0] rdata_q;
  logic signed [stbs_pkg::VAL_W-1:0] value_q;

  logic [CW-1:0] count_q;
  logic [CW-1:0] lo_q, hix_q, mid_q;
  logic [CW-1:0] lo_n, hix_n, mid_n, mid0, span;
  logic [CW-1:0] pos_sel;
  logic [CW+stbs_pkg::POS_W-1:0] pos_ext;
  logic [AW-1:0] rd_addr;
  logic [stbs_pkg::POS_W-1:0] position_q;
  logic found_q;
  logic eq, gt, done, wr_en;

  always_comb begin
    eq      = (rdata_q == value_q);
    gt      = (rdata_q > value_q);
    lo_n    = gt ? lo_q : mid_q + ONE_C;
    hix_n   = gt ? mid_q : hix_q;
    done    = eq || (lo_n >= hix_n);
    span    = hix_n - lo_n - ONE_C;
    mid_n   = lo_n + (span >> 1);
    mid0    = (count_q - ONE_C) >> 1;
    rd_addr = cmd_i.start ? mid0[AW-1:0] : mid_n[AW-1:0];
    pos_sel = eq ? mid_q : lo_n;
    pos_ext = {{stbs_pkg::POS_W{1'b0}}, pos_sel};
    wr_en   = cmd_i.load && (count_q < DEPTH_C);
  end

  assign status_o.empty = (count_q == '0);
  assign status_o.done  = done;
  assign position_o     = position_q;
  assign found_o        = found_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[AW-1:0]] <= value_i;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.clear) begin
      count_q <= '0;
    end else if (wr_en) begin
      count_q <= count_q + ONE_C;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      value_q <= value_i;
      lo_q    <= '0;
      hix_q   <= count_q;
      mid_q   <= mid0;
      if (count_q == '0) begin
        position_q <= '0;
        found_q    <= 1'b0;
      end
    end else if (cmd_i.step) begin
      lo_q  <= lo_n;
      hix_q <= hix_n;
      mid_q <= mid_n;
      if (done) begin
        position_q <= pos_ext[stbs_pkg::POS_W-1:0];
        found_q    <= eq;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("Fill count exceeds the table depth.");

  a_bounds_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (lo_q < hix_q) && (mid_q >= lo_q) && (mid_q < hix_q))
    else $error("Probe lies outside the search bounds.");

  a_found_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && done && eq) |=> found_q)
    else $error("Match was not recorded as found.");

endmodule

// File: src/stbs_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the binary search block.
// Drives the datapath through stbs_pkg::cmd_t and owns both handshakes.
module stbs_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [stbs_pkg::OP_W-1:0] in_op_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  input  stbs_pkg::status_t         status_i,
  output stbs_pkg::cmd_t            cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RESULT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.load  = accept && (in_op_i == stbs_pkg::OP_LOAD);
    cmd_o.clear = accept && (in_op_i == stbs_pkg::OP_CLEAR);
    cmd_o.start = accept && (in_op_i == stbs_pkg::OP_QUERY);
    cmd_o.step  = (state_q == ST_SEARCH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_o.start) begin
            if (status_i.empty) begin
              state_q     <= ST_RESULT;
              out_valid_q <= 1'b1;
            end else begin
              state_q <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          if (status_i.done) begin
            state_q     <= ST_RESULT;
            out_valid_q <= 1'b1;
          end
        end
        ST_RESULT: begin
          if (out_ready_i) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b0;
          end
        end
        default: begin
          state_q     <= ST_IDLE;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

  a_no_write_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !cmd_o.load && !cmd_o.clear && !cmd_o.start)
    else $error("Table command issued while a query is in flight.");

  a_query_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.start && !status_i.empty) |=> (state_q == ST_SEARCH))
    else $error("Query on a filled table did not start a search.");

  a_valid_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q == (state_q == ST_RESULT))
    else $error("Result valid disagrees with the controller state.");

endmodule

// File: verif/sorted_table_binary_search_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_table_binary_search_core: loads, clears and
// queries, with results checked against a built-in search predictor.
// Depends on stbs_pkg, stbs_if and the core with its submodules.
module sorted_table_binary_search_core_tb;

  localparam int TABLE_DEPTH = 1024;
  localparam logic [stbs_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic signed [stbs_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [stbs_pkg::VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [stbs_pkg::POS_W-1:0] position;
    logic                       found;
  } search_result_t;

  logic clk_i;
  logic rst_ni;

  stbs_in_if  in_ch ();
  stbs_out_if out_ch ();

  sorted_table_binary_search_core #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  logic signed [stbs_pkg::VAL_W-1:0] model_table [TABLE_DEPTH];
  int                                model_count;
  search_result_t                    expected_results [$];
  int                                error_count;
  int                                results_checked;
  int                                items_sent;
  logic                              gaps_on;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic search_result_t search_model(
    input logic signed [stbs_pkg::VAL_W-1:0] key);
    search_result_t r;
    int             lo;
    int             hi;
    int             mid;
    lo = 0;
    hi = model_count - 1;
    r.found = 1'b0;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (model_table[mid] == key) begin
        r.position = mid[stbs_pkg::POS_W-1:0];
        r.found = 1'b1;
        return r;
      end
      if (model_table[mid] > key) hi = mid - 1;
      else lo = mid + 1;
    end
    r.position = lo[stbs_pkg::POS_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i) begin
    search_result_t exp_r;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          $error("Result transfer with no query outstanding: position %0d found %0b",
                 out_ch.position, out_ch.found);
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_ch.position !== exp_r.position) begin
            $error("position: expected %0d, actual %0d", exp_r.position, out_ch.position);
            error_count++;
          end
          if (out_ch.found !== exp_r.found) begin
            $error("found: expected %0b, actual %0b", exp_r.found, out_ch.found);
            error_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.op)
          stbs_pkg::OP_LOAD: begin
            if (model_count < TABLE_DEPTH) begin
              model_table[model_count] = in_ch.search_value;
              model_count++;
            end
          end
          stbs_pkg::OP_CLEAR: model_count = 0;
          stbs_pkg::OP_QUERY: expected_results.push_back(search_model(in_ch.search_value));
          default: ;
        endcase
      end
    end
  end

  initial begin
    out_ch.ready = 1'b1;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_item(input logic [stbs_pkg::OP_W-1:0] op_code,
                           input logic signed [stbs_pkg::VAL_W-1:0] value);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.op           <= op_code;
    in_ch.search_value <= value;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic signed [stbs_pkg::VAL_W-1:0] random_value(input int mode);
    case (mode)
      0:       return int'($urandom_range(0, 40)) - 20;
      1:       return $signed($urandom) >>> $urandom_range(0, 20);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_table();
    send_item(stbs_pkg::OP_QUERY, 0);
    send_item(stbs_pkg::OP_QUERY, VAL_MIN);
    send_item(stbs_pkg::OP_QUERY, VAL_MAX);
    send_item(OP_UNUSED, 32'h5a5a_a5a5);
    send_item(stbs_pkg::OP_QUERY, -1);
  endtask

  task automatic test_value_extremes();
    send_item(stbs_pkg::OP_LOAD, VAL_MIN);
    send_item(stbs_pkg::OP_LOAD, -1);
    send_item(stbs_pkg::OP_LOAD, 0);
    send_item(stbs_pkg::OP_LOAD, 1);
    send_item(stbs_pkg::OP_LOAD, VAL_MAX);
    send_item(stbs_pkg::OP_QUERY, VAL_MIN);
    send_item(stbs_pkg::OP_QUERY, -1);
    send_item(stbs_pkg::OP_QUERY, 0);
    send_item(stbs_pkg::OP_QUERY, 1);
    send_item(stbs_pkg::OP_QUERY, VAL_MAX);
    send_item(stbs_pkg::OP_QUERY, -2);
    send_item(stbs_pkg::OP_QUERY, 2);
    send_item(stbs_pkg::OP_CLEAR, 0);
  endtask

  task automatic test_duplicates_and_unsorted();
    send_item(stbs_pkg::OP_LOAD, 5);
    send_item(stbs_pkg::OP_LOAD, 5);
    send_item(stbs_pkg::OP_LOAD, 5);
    send_item(stbs_pkg::OP_LOAD, 7);
    send_item(stbs_pkg::OP_QUERY, 5);
    send_item(stbs_pkg::OP_QUERY, 6);
    send_item(stbs_pkg::OP_CLEAR, 0);
    send_item(stbs_pkg::OP_LOAD, 9);
    send_item(stbs_pkg::OP_LOAD, 3);
    send_item(stbs_pkg::OP_LOAD, 1);
    send_item(stbs_pkg::OP_QUERY, 3);
    send_item(stbs_pkg::OP_QUERY, 1);
    send_item(stbs_pkg::OP_QUERY, 10);
    send_item(stbs_pkg::OP_CLEAR, 0);
  endtask

  task automatic test_full_table();
    send_item(stbs_pkg::OP_CLEAR, 0);
    for (int i = 0; i < TABLE_DEPTH; i++) send_item(stbs_pkg::OP_LOAD, i * 8 - 4000);
    // The table is full, so these loads must leave it unchanged.
    send_item(stbs_pkg::OP_LOAD, VAL_MIN);
    send_item(stbs_pkg::OP_LOAD, VAL_MAX);
    send_item(stbs_pkg::OP_QUERY, -4000);
    send_item(stbs_pkg::OP_QUERY, (TABLE_DEPTH - 1) * 8 - 4000);
    send_item(stbs_pkg::OP_QUERY, VAL_MIN);
    send_item(stbs_pkg::OP_QUERY, VAL_MAX);
    send_item(stbs_pkg::OP_QUERY, 3);
    send_item(stbs_pkg::OP_QUERY, 512 * 8 - 4000);
    for (int i = 0; i < 20; i++) begin
      send_item(stbs_pkg::OP_QUERY, int'($urandom_range(0, 8300)) - 4100);
    end
    send_item(stbs_pkg::OP_CLEAR, 0);
    send_item(stbs_pkg::OP_QUERY, 0);
  endtask

  task automatic run_random_sequence();
    int                                vals [$];
    int                                n;
    int                                nq;
    int                                mode;
    int                                pick;
    logic signed [stbs_pkg::VAL_W-1:0] v;
    if ($urandom_range(0, 3) != 0) send_item(stbs_pkg::OP_CLEAR, $urandom);
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 200) : $urandom_range(0, 24);
    mode = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) vals.push_back(random_value(mode));
    vals.sort();
    if (n > 1 && $urandom_range(0, 9) == 0) vals.shuffle();
    foreach (vals[i]) send_item(stbs_pkg::OP_LOAD, vals[i]);
    nq = $urandom_range(1, 10);
    for (int i = 0; i < nq; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4 && vals.size() > 0) begin
        v = vals[$urandom_range(0, vals.size() - 1)];
      end else if (pick < 6 && vals.size() > 0) begin
        v = vals[$urandom_range(0, vals.size() - 1)] + ($urandom_range(0, 1) ? 1 : -1);
      end else begin
        v = random_value(mode);
      end
      send_item(stbs_pkg::OP_QUERY, v);
    end
    if ($urandom_range(0, 7) == 0) send_item(OP_UNUSED, $urandom);
    if ($urandom_range(0, 7) == 0) send_item(stbs_pkg::OP_LOAD, $urandom);
  endtask

  task automatic test_random_sequences(input int item_goal);
    int start_count;
    int pause_done;
    start_count = items_sent;
    pause_done = 0;
    while (items_sent - start_count < item_goal) begin
      run_random_sequence();
      if (!pause_done && items_sent - start_count > item_goal / 2) begin
        wait_for_results();
        pause_done = 1;
      end
    end
  endtask

  initial begin
    int random_start;
    rst_ni             = 1'b0;
    gaps_on            = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.op           = stbs_pkg::OP_LOAD;
    in_ch.search_value = '0;
    model_count        = 0;
    error_count        = 0;
    results_checked    = 0;
    items_sent         = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    gaps_on = 1'b1;
    test_empty_table();
    test_value_extremes();
    test_duplicates_and_unsorted();
    test_full_table();
    random_start = items_sent;
    test_random_sequences(80);
    gaps_on = 1'b0;
    test_random_sequences(40);

    wait_for_results();
    repeat (30) @(posedge clk_i);
    $display("Run covered empty, extreme, duplicate, unsorted and full-table searches");
    $display("plus %0d random items; %0d results checked.", items_sent - random_start,
             results_checked);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
